>>> rtl/assert_macros.svh
// assertion helpers used by sck_sorter
// each macro checks on the rising edge of aclk and is off while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check with a message
`define SCK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication check: antecedent then consequent in the same cycle
`define SCK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication check: antecedent then consequent in the next cycle
`define SCK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sck_pkg.sv
// ----------------------------------------------------------------------------
// sck_pkg
// Shared sizes, constants and control structs of the sorted cost set keeper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sck_pkg;

    // number of set entries held in the store
    localparam int ENTRIES = 16;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COST_W  = 32;
    localparam int TAG_W   = 16;
    localparam int POS_W   = 4;
    localparam int ACT_W   = 5;
    localparam int RIDX_W  = 4;
    localparam int ENTRY_W = COST_W + TAG_W;

    // cost held by an entry that was never written
    localparam logic [COST_W-1:0] LARGEST_KEY = 32'h7FFF_FFFF;

    // register value after reset
    localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // request from the channel side to the sorter
    typedef struct packed {
        logic               op;
        logic [COST_W-1:0]  cost;
        logic [TAG_W-1:0]   tag;
        logic [RIDX_W-1:0]  read_index;
        logic [IDX_W-1:0]   last;
    } sck_req_t;

    // finished result from the sorter
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COST_W-1:0]  cost;
        logic [TAG_W-1:0]   tag;
    } sck_res_t;

endpackage

`default_nettype wire

>>> rtl/sorted_cost_set_keeper.sv
// Insert: the walk shifts k entries up one slot each, k = 0..ENTRIES-1, then drops the new
// entry in place. Read: a registered RAM read, then the result. Both results pass through
// the output register. One item at a time; the walk moves one RAM slot per cycle, bounded
// by the single write port. The next item is taken while a result waits in the output register.
// Reset (aresetn low, synchronous): active_entries = 16, every entry reads as cost
// 0x7FFFFFFF and tag 0 through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_cost_set_keeper
// Keeps cost/tag entries in ascending cost order with a stable insertion walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_cost_set_keeper (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sck_pkg::ACT_W-1:0]    cfg_data,
    // input items
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_op,
    input  wire logic [sck_pkg::COST_W-1:0]   s_new_cost,
    input  wire logic [sck_pkg::TAG_W-1:0]    s_new_tag,
    input  wire logic [sck_pkg::RIDX_W-1:0]   s_read_index,
    // results
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [sck_pkg::POS_W-1:0]    m_position,
    output logic      [sck_pkg::COST_W-1:0]   m_entry_cost,
    output logic      [sck_pkg::TAG_W-1:0]    m_entry_tag
);
    import sck_pkg::*;

    logic [ACT_W-1:0]  active_reg;
    logic [IDX_W-1:0]  last_slot;
    sck_req_t          req;
    sck_res_t          res;
    logic              res_valid;
    logic              res_ready;
    logic              m_valid_reg;
    sck_res_t          m_res_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            active_reg <= cfg_data;
        end
    end

    // last active slot, active count clamped to 1..ENTRIES
    always_comb begin
        if (active_reg == '0) begin
            last_slot = '0;
        end else if (32'(active_reg) > ENTRIES) begin
            last_slot = IDX_W'(ENTRIES - 1);
        end else begin
            last_slot = IDX_W'(active_reg - 1'b1);
        end
    end

    assign req.op         = s_op;
    assign req.cost       = s_new_cost;
    assign req.tag        = s_new_tag;
    assign req.read_index = s_read_index;
    assign req.last       = last_slot;

    sck_sorter u_sorter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_position   = m_res_reg.position;
    assign m_entry_cost = m_res_reg.cost;
    assign m_entry_tag  = m_res_reg.tag;

endmodule

`default_nettype wire

>>> rtl/sck_ram.sv
// ----------------------------------------------------------------------------
// sck_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sck_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/sck_sorter.sv
// ----------------------------------------------------------------------------
// sck_sorter
// Insertion walk over the entry RAM: shifts larger entries up one slot per
// cycle and drops the new entry in place; also serves indexed reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sck_sorter (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire sck_pkg::sck_req_t req,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output sck_pkg::sck_res_t     res
);
    import sck_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [COST_W-1:0]  new_cost_reg;
    logic [TAG_W-1:0]   new_tag_reg;
    logic [RIDX_W-1:0]  ridx_reg;
    logic               in_range_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;
    sck_res_t           res_reg, res_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [COST_W-1:0]  pred_cost;
    logic [TAG_W-1:0]   pred_tag;
    logic               accept;
    logic               req_in_range;

    // entry store
    sck_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready    = (state_reg == ST_IDLE);
    assign accept       = req_valid && req_ready;
    assign req_in_range = (32'(req.read_index) < ENTRIES);
    assign res_valid    = (state_reg == ST_OUT);
    assign res          = res_reg;

    // never-written entries read as the reset value
    assign pred_cost = rd_valid_reg ? rd_data[ENTRY_W-1 -: COST_W] : LARGEST_KEY;
    assign pred_tag  = rd_valid_reg ? rd_data[TAG_W-1:0] : '0;

    // sequencer
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        wr_en      = 1'b0;
        wr_addr    = j_reg;
        wr_data    = {new_cost_reg, new_tag_reg};
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    if (req.op == OP_INSERT) begin
                        j_next     = req.last;
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WALK: begin
                wr_en = 1'b1;
                if ((j_reg == '0) || !($signed(new_cost_reg) < $signed(pred_cost))) begin
                    // new entry lands here
                    res_next.position = POS_W'(j_reg);
                    res_next.cost     = new_cost_reg;
                    res_next.tag      = new_tag_reg;
                    state_next        = ST_OUT;
                end else begin
                    // predecessor moves up one slot
                    wr_data = {pred_cost, pred_tag};
                    j_next  = j_reg - 1'b1;
                end
            end
            ST_FETCH: begin
                res_next.position = POS_W'(ridx_reg);
                res_next.cost     = in_range_reg ? pred_cost : '0;
                res_next.tag      = in_range_reg ? pred_tag : '0;
                state_next        = ST_OUT;
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read address: indexed read, or the slot below the walking position
    always_comb begin
        if ((state_reg == ST_IDLE) && (req.op == OP_READ)) begin
            rd_addr = IDX_W'(req.read_index);
        end else begin
            rd_addr = j_next - 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // walk position, captured request and result
    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        res_reg      <= res_next;
        rd_valid_reg <= valid_reg[rd_addr];
        if (accept) begin
            new_cost_reg <= req.cost;
            new_tag_reg  <= req.tag;
            ridx_reg     <= req.read_index;
            in_range_reg <= req_in_range;
        end
    end

    // checks
    `SCK_ASSERT_IMP(a_no_write_idle, state_reg == ST_IDLE, !wr_en,
        "entry write outside the insert walk")
    `SCK_ASSERT_IMP(a_no_rw_clash, wr_en && (state_next == ST_WALK), wr_addr != rd_addr,
        "shift write hits the slot being read")
    `SCK_ASSERT_NXT(a_walk_step, (state_reg == ST_WALK) && (state_next == ST_WALK),
        j_reg == IDX_W'($past(j_reg) - 1'b1), "walk position did not step down")
    `SCK_ASSERT_NXT(a_accept_busy, accept, state_reg != ST_IDLE,
        "accepted request left the sequencer idle")

endmodule

`default_nettype wire
